>>> rtl/dps_pkg.sv
// Shared types, character codes and helpers for the drive path sanitiser.
`timescale 1ns / 1ps
`default_nettype none
package dps_pkg;

   localparam int MaxPathBytesDefault = 256;
   localparam int MountWidth          = 26;

   localparam logic [7:0] CharNul          = 8'h00;
   localparam logic [7:0] CharColon        = 8'h3A;
   localparam logic [7:0] CharSlash        = 8'h2F;
   localparam logic [7:0] CharBackslash    = 8'h5C;
   localparam logic [7:0] CharDot          = 8'h2E;
   localparam logic [7:0] CharDriveDefault = 8'h43;
   localparam logic [7:0] CharUpperA       = 8'h41;
   localparam logic [7:0] CharUpperZ       = 8'h5A;
   localparam logic [7:0] CharLowerA       = 8'h61;
   localparam logic [7:0] CharLowerZ       = 8'h7A;
   localparam logic [7:0] CaseOffset       = 8'h20;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_EMPTY       = 3'd1,
      STATUS_UNSAFE      = 3'd2,
      STATUS_TOO_LONG    = 3'd3,
      STATUS_NOT_MOUNTED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_BODY   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      COMP_START  = 2'd0,
      COMP_ONEDOT = 2'd1,
      COMP_TWODOT = 2'd2,
      COMP_OTHER  = 2'd3
   } comp_type;

   typedef struct packed {
      logic       is_verdict;
      logic [7:0] path_char;
      status_type status;
      logic [4:0] volume_index;
      logic [7:0] path_length;
      logic       last_of_item;
   } rsp_item_type;

   // up to two result beats produced by one request beat, in order
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   function automatic logic [7:0] fold_case(logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CharLowerA && c <= CharLowerZ) begin
         r = c - CaseOffset;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/dps_if.sv
// Request and response channel interfaces of the drive path sanitiser.
`timescale 1ns / 1ps
`default_nettype none
interface dps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface dps_rsp_if import dps_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             is_verdict;
   logic [7:0]       path_char;
   status_type       status;
   logic [4:0]       volume_index;
   logic [7:0]       path_length;
   logic             last_of_item;

   modport source (output valid, output is_verdict, output path_char, output status,
                   output volume_index, output path_length, output last_of_item,
                   input ready);
   modport sink (input valid, input is_verdict, input path_char, input status,
                 input volume_index, input path_length, input last_of_item,
                 output ready);
endinterface
`default_nettype wire

>>> rtl/dps_result_queue.sv
// Two-entry result buffer between the path walker and the response channel.
`timescale 1ns / 1ps
`default_nettype none
module dps_result_queue import dps_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room_two,
   dps_rsp_if.source     rsp_beat
);

   rsp_item_type slot_ff [2];
   rsp_item_type slot_in [2];
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         pop;
   logic [1:0]   base;

   assign pop      = (count_ff != 2'd0) && rsp_beat.ready;
   assign base     = count_ff - {1'b0, pop};
   assign room_two = (base == 2'd0);

   always_comb begin
      slot_in = slot_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push.count != 2'd0) begin
         slot_in[base[0]] = push.first;
      end
      if (push.count == 2'd2) begin
         slot_in[1] = push.second;
      end
      count_in = base + push.count;
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_beat.valid        = (count_ff != 2'd0);
   assign rsp_beat.is_verdict   = slot_ff[0].is_verdict;
   assign rsp_beat.path_char    = slot_ff[0].path_char;
   assign rsp_beat.status       = slot_ff[0].status;
   assign rsp_beat.volume_index = slot_ff[0].volume_index;
   assign rsp_beat.path_length  = slot_ff[0].path_length;
   assign rsp_beat.last_of_item = slot_ff[0].last_of_item;

endmodule
`default_nettype wire

>>> rtl/dps_core.sv
// Input register, path walking state and per-byte result logic.
`timescale 1ns / 1ps
`default_nettype none
module dps_core import dps_pkg::*; #(
   parameter int MaxPathBytes = MaxPathBytesDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [MountWidth-1:0] mounted_letters,
   input  wire logic                  room_two,
   dps_req_if.sink                    req_beat,
   output push_type                   push
);

   localparam int CountWidth = $clog2(MaxPathBytes);
   localparam logic [CountWidth-1:0] EmitLimit = CountWidth'(MaxPathBytes - 1);

   typedef struct packed {
      logic                  skip;
      comp_type              comp;
      logic                  unsafe;
      logic [CountWidth-1:0] count;
      logic                  overflow;
   } walk_type;

   typedef struct packed {
      walk_type   walk;
      logic       emit;
      logic [7:0] ch;
   } step_type;

   localparam walk_type WalkReset = '{skip: 1'b1, comp: COMP_START, unsafe: 1'b0,
                                      count: '0, overflow: 1'b0};

   function automatic step_type walk_byte(walk_type w, logic [7:0] c);
      step_type s;
      logic     sep;
      sep    = (c == CharSlash) || (c == CharBackslash);
      s.walk = w;
      s.emit = 1'b0;
      s.ch   = sep ? CharSlash : c;
      if (!(w.skip && sep)) begin
         s.walk.skip = 1'b0;
         if (c == CharColon) begin
            s.walk.unsafe = 1'b1;
         end
         if (sep) begin
            if (w.comp == COMP_TWODOT) begin
               s.walk.unsafe = 1'b1;
            end
            s.walk.comp = COMP_START;
         end else if (c == CharDot) begin
            unique case (w.comp)
               COMP_START:  s.walk.comp = COMP_ONEDOT;
               COMP_ONEDOT: s.walk.comp = COMP_TWODOT;
               default:     s.walk.comp = COMP_OTHER;
            endcase
         end else begin
            s.walk.comp = COMP_OTHER;
         end
         if (w.count < EmitLimit) begin
            s.walk.count = w.count + CountWidth'(1);
            s.emit       = 1'b1;
         end else begin
            s.walk.overflow = 1'b1;
         end
      end
      return s;
   endfunction

   function automatic rsp_item_type make_verdict(walk_type w, logic [7:0] drive,
                                                  logic [MountWidth-1:0] mounted);
      rsp_item_type r;
      logic         letter_ok;
      logic [4:0]   vol;
      letter_ok      = (drive >= CharUpperA) && (drive <= CharUpperZ);
      vol            = letter_ok ? 5'(drive - CharUpperA) : 5'd0;
      r              = '0;
      r.is_verdict   = 1'b1;
      r.volume_index = vol;
      r.path_length  = 8'(w.count);
      if (w.skip) begin
         r.status = STATUS_EMPTY;
      end else if (w.unsafe || (w.comp == COMP_TWODOT)) begin
         r.status = STATUS_UNSAFE;
      end else if (w.overflow) begin
         r.status = STATUS_TOO_LONG;
      end else if (!letter_ok || !mounted[vol]) begin
         r.status = STATUS_NOT_MOUNTED;
      end else begin
         r.status = STATUS_OK;
      end
      return r;
   endfunction

   function automatic rsp_item_type make_emit(logic [7:0] ch);
      rsp_item_type r;
      r           = '0;
      r.path_char = ch;
      return r;
   endfunction

   logic         in_valid_ff;
   logic         in_valid_in;
   logic [7:0]   in_char_ff;
   phase_type    phase_ff;
   phase_type    phase_in;
   logic [7:0]   held_ff;
   logic [7:0]   held_in;
   logic [7:0]   drive_ff;
   logic [7:0]   drive_in;
   walk_type     walk_ff;
   walk_type     walk_in;

   logic         go;
   logic         take;
   step_type     held_step;
   walk_type     cur_base;
   step_type     cur_step;
   rsp_item_type verdict_item;
   logic         lead_valid;
   rsp_item_type lead_item;
   logic         tail_valid;
   rsp_item_type tail_item;

   assign go             = in_valid_ff && room_two;
   assign req_beat.ready = !in_valid_ff || go;
   assign take           = req_beat.valid && req_beat.ready;
   assign in_valid_in    = take || (in_valid_ff && !go);

   // held first byte is walked ahead of the current one when no drive prefix
   assign held_step    = walk_byte(walk_ff, held_ff);
   assign cur_base     = (phase_ff == PHASE_SECOND) ? held_step.walk : walk_ff;
   assign cur_step     = walk_byte(cur_base, in_char_ff);
   assign verdict_item = make_verdict(cur_base, drive_ff, mounted_letters);

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      drive_in   = drive_ff;
      walk_in    = walk_ff;
      lead_valid = 1'b0;
      lead_item  = make_emit(held_step.ch);
      tail_valid = 1'b0;
      tail_item  = make_emit(cur_step.ch);
      push       = '0;

      if (go) begin
         unique case (phase_ff)
            PHASE_FIRST: begin
               if (in_char_ff == CharNul) begin
                  tail_valid = 1'b1;
                  tail_item  = verdict_item;
               end else begin
                  held_in  = in_char_ff;
                  phase_in = PHASE_SECOND;
               end
            end
            PHASE_SECOND: begin
               if (in_char_ff == CharColon) begin
                  drive_in = fold_case(held_ff);
                  phase_in = PHASE_BODY;
               end else begin
                  lead_valid = held_step.emit;
                  phase_in   = PHASE_BODY;
                  if (in_char_ff == CharNul) begin
                     tail_valid = 1'b1;
                     tail_item  = verdict_item;
                  end else begin
                     tail_valid = cur_step.emit;
                     walk_in    = cur_step.walk;
                  end
               end
            end
            PHASE_BODY: begin
               if (in_char_ff == CharNul) begin
                  tail_valid = 1'b1;
                  tail_item  = verdict_item;
               end else begin
                  tail_valid = cur_step.emit;
                  walk_in    = cur_step.walk;
               end
            end
            default: begin
               phase_in = PHASE_FIRST;
            end
         endcase

         // verdict: whole path state back to reset
         if (in_char_ff == CharNul) begin
            phase_in = PHASE_FIRST;
            held_in  = CharNul;
            drive_in = CharDriveDefault;
            walk_in  = WalkReset;
         end
      end

      if (lead_valid) begin
         push.first  = lead_item;
         push.second = tail_item;
         push.count  = {1'b0, lead_valid} + {1'b0, tail_valid};
         if (tail_valid) begin
            push.second.last_of_item = 1'b1;
         end else begin
            push.first.last_of_item = 1'b1;
         end
      end else begin
         push.first              = tail_item;
         push.first.last_of_item = 1'b1;
         push.count              = {1'b0, tail_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_char_ff <= req_beat.char_code;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PHASE_FIRST;
         held_ff     <= CharNul;
         drive_ff    <= CharDriveDefault;
         walk_ff     <= WalkReset;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         drive_ff    <= drive_in;
         walk_ff     <= walk_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/drive_path_sanitizer_unit.sv
// Top level of the drive path sanitiser: mount mask register, walker and result buffer.
// Takes a path one byte per beat, ended by a zero byte, and returns the relative path
// bytes (backslash turned into slash, drive prefix and leading separators dropped)
// followed by one verdict beat with status, volume index and emitted length. A request
// beat is registered in the input register and walked once the result buffer has room
// for two results; the results land in a two-entry buffer that presents them. One byte is
// accepted per cycle while the response side keeps up; the byte after a drive-less first
// character releases two results and holds the request side, since the two-entry result
// buffer must drain. The user must write the mount mask through csr_write_en and
// csr_write_data only between paths; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module drive_path_sanitizer_unit import dps_pkg::*; #(
   parameter int MaxPathBytes = MaxPathBytesDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [MountWidth-1:0] csr_write_data,
   dps_req_if.sink                    req_beat,
   dps_rsp_if.source                  rsp_beat
);

   logic [MountWidth-1:0] mounted_ff;
   logic                  room_two;
   push_type              push;

   always_ff @(posedge clock) begin
      if (reset) begin
         mounted_ff <= '0;
      end else if (csr_write_en) begin
         mounted_ff <= csr_write_data;
      end
   end

   dps_core #(
      .MaxPathBytes (MaxPathBytes)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .mounted_letters (mounted_ff),
      .room_two        (room_two),
      .req_beat        (req_beat),
      .push            (push)
   );

   dps_result_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room_two (room_two),
      .rsp_beat (rsp_beat)
   );

endmodule
`default_nettype wire

>>> tb/tb_drive_path_sanitizer_unit.sv
// Self-checking testbench for the drive path sanitiser: streamed paths, predicted beats.
`timescale 1ns / 1ps
module tb_drive_path_sanitizer_unit;
   import dps_pkg::*;

   localparam int MaxBytes = MaxPathBytesDefault;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en;
   logic [MountWidth-1:0] csr_write_data;

   dps_req_if req_if ();
   dps_rsp_if rsp_if ();

   drive_path_sanitizer_unit #(.MaxPathBytes(MaxBytes)) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_beat       (req_if),
      .rsp_beat       (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // path walker mirror
   logic [MountWidth-1:0] mount_mask;
   phase_type             walk_phase;
   logic [7:0]            held_char;
   logic [7:0]            drive_char;
   logic                  skip_sep;
   comp_type              comp_state;
   logic                  unsafe_seen;
   logic                  overflow_seen;
   int                    emit_count;

   rsp_item_type          expected_beats[$];
   logic [7:0]            path_bytes[$];
   int                    mismatch_count = 0;

   function automatic void clear_walk();
      walk_phase    = PHASE_FIRST;
      held_char     = CharNul;
      drive_char    = CharDriveDefault;
      skip_sep      = 1'b1;
      comp_state    = COMP_START;
      unsafe_seen   = 1'b0;
      overflow_seen = 1'b0;
      emit_count    = 0;
   endfunction

   function automatic void emit_body_char(logic [7:0] c);
      logic         is_sep;
      rsp_item_type r;
      is_sep = (c == CharSlash) || (c == CharBackslash);
      if (skip_sep && is_sep) begin
         return;
      end
      skip_sep = 1'b0;
      if (c == CharColon) begin
         unsafe_seen = 1'b1;
      end
      if (is_sep) begin
         if (comp_state == COMP_TWODOT) begin
            unsafe_seen = 1'b1;
         end
         comp_state = COMP_START;
      end else if (c == CharDot) begin
         case (comp_state)
            COMP_START: begin
               comp_state = COMP_ONEDOT;
            end
            COMP_ONEDOT: begin
               comp_state = COMP_TWODOT;
            end
            default: begin
               comp_state = COMP_OTHER;
            end
         endcase
      end else begin
         comp_state = COMP_OTHER;
      end
      if (emit_count < MaxBytes - 1) begin
         emit_count++;
         r           = '0;
         r.path_char = is_sep ? CharSlash : c;
         r.status    = STATUS_OK;
         expected_beats.push_back(r);
      end else begin
         overflow_seen = 1'b1;
      end
   endfunction

   function automatic void issue_verdict();
      logic         letter_ok;
      logic [4:0]   vol;
      status_type   st;
      rsp_item_type r;
      letter_ok = (drive_char >= CharUpperA) && (drive_char <= CharUpperZ);
      vol       = letter_ok ? 5'(drive_char - CharUpperA) : 5'd0;
      if (comp_state == COMP_TWODOT) begin
         unsafe_seen = 1'b1;
      end
      if (skip_sep) begin
         st = STATUS_EMPTY;
      end else if (unsafe_seen) begin
         st = STATUS_UNSAFE;
      end else if (overflow_seen) begin
         st = STATUS_TOO_LONG;
      end else if (!letter_ok || !mount_mask[vol]) begin
         st = STATUS_NOT_MOUNTED;
      end else begin
         st = STATUS_OK;
      end
      r              = '0;
      r.is_verdict   = 1'b1;
      r.status       = st;
      r.volume_index = vol;
      r.path_length  = 8'(emit_count);
      expected_beats.push_back(r);
      clear_walk();
   endfunction

   function automatic void predict_byte(logic [7:0] c);
      int           prior_size;
      logic [7:0]   letter;
      rsp_item_type r;
      prior_size = expected_beats.size();
      case (walk_phase)
         PHASE_FIRST: begin
            if (c == CharNul) begin
               issue_verdict();
            end else begin
               held_char  = c;
               walk_phase = PHASE_SECOND;
            end
         end
         PHASE_SECOND: begin
            walk_phase = PHASE_BODY;
            if (c == CharColon) begin
               letter = held_char;
               if (letter >= CharLowerA && letter <= CharLowerZ) begin
                  letter = letter - CaseOffset;
               end
               drive_char = letter;
            end else begin
               emit_body_char(held_char);
               if (c == CharNul) begin
                  issue_verdict();
               end else begin
                  emit_body_char(c);
               end
            end
         end
         default: begin
            if (c == CharNul) begin
               issue_verdict();
            end else begin
               emit_body_char(c);
            end
         end
      endcase
      if (expected_beats.size() > prior_size) begin
         r              = expected_beats.pop_back();
         r.last_of_item = 1'b1;
         expected_beats.push_back(r);
      end
   endfunction

   // request driver: bursts with random gaps
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.char_code <= CharNul;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_byte(req_if.char_code);
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (path_bytes.size() != 0) begin
               req_if.valid     <= 1'b1;
               req_if.char_code <= path_bytes.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall pattern
   int   stall_tick;
   int   stall_mode;

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_tick   <= 0;
         stall_mode   <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.is_verdict   = rsp_if.is_verdict;
            got.path_char    = rsp_if.path_char;
            got.status       = rsp_if.status;
            got.volume_index = rsp_if.volume_index;
            got.path_length  = rsp_if.path_length;
            got.last_of_item = rsp_if.last_of_item;
            if (expected_beats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected beat: v=%0b c=%h st=%0d vol=%0d len=%0d last=%0b",
                           $realtime, got.is_verdict, got.path_char, got.status,
                           got.volume_index, got.path_length, got.last_of_item);
               end
            end else begin
               want = expected_beats.pop_front();
               if (got.is_verdict !== want.is_verdict || got.path_char !== want.path_char ||
                   got.status !== want.status || got.volume_index !== want.volume_index ||
                   got.path_length !== want.path_length ||
                   got.last_of_item !== want.last_of_item) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: beat mismatch: exp v=%0b c=%h st=%0d vol=%0d len=%0d last=%0b",
                              $realtime, want.is_verdict, want.path_char, want.status,
                              want.volume_index, want.path_length, want.last_of_item);
                     $display("%0t:                got v=%0b c=%h st=%0d vol=%0d len=%0d last=%0b",
                              $realtime, got.is_verdict, got.path_char, got.status,
                              got.volume_index, got.path_length, got.last_of_item);
                  end
               end
            end
         end
         stall_tick <= stall_tick + 1;
         if (stall_tick % 128 == 0) begin
            stall_mode <= $urandom_range(0, 3);
         end
         case (stall_mode)
            0: begin
               rsp_if.ready <= 1'b1;
            end
            1: begin
               rsp_if.ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
               rsp_if.ready <= (stall_tick % 5 != 0);
            end
            default: begin
               rsp_if.ready <= ($urandom_range(0, 9) < 3);
            end
         endcase
      end
   end

   // stimulus helpers
   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         path_bytes.push_back(s[i]);
      end
      path_bytes.push_back(CharNul);
   endfunction

   function automatic logic [7:0] random_sep();
      return ($urandom_range(0, 1) != 0) ? CharSlash : CharBackslash;
   endfunction

   function automatic logic [7:0] random_letter();
      logic [7:0] base;
      base = ($urandom_range(0, 1) != 0) ? CharLowerA : CharUpperA;
      return base + 8'($urandom_range(0, 25));
   endfunction

   function automatic void add_long_path(int body_len);
      path_bytes.push_back(CharUpperA + 8'($urandom_range(0, 25)));
      path_bytes.push_back(CharColon);
      for (int i = 0; i < body_len; i++) begin
         path_bytes.push_back((i % 8 == 7) ? CharSlash : random_letter());
      end
      path_bytes.push_back(CharNul);
   endfunction

   function automatic void add_random_path();
      int pick;
      int n_comp;
      int n_char;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         // raw noise, may leave a path open or close one early
         repeat ($urandom_range(1, 8)) begin
            path_bytes.push_back(8'($urandom_range(0, 255)));
         end
         return;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         path_bytes.push_back(random_letter());
         path_bytes.push_back(CharColon);
      end else if (pick == 6) begin
         path_bytes.push_back(8'($urandom_range(1, 255)));
         path_bytes.push_back(CharColon);
      end
      repeat ($urandom_range(0, 2)) begin
         path_bytes.push_back(random_sep());
      end
      n_comp = $urandom_range(0, 4);
      for (int k = 0; k < n_comp; k++) begin
         case ($urandom_range(0, 7))
            0: begin
               path_bytes.push_back(CharDot);
            end
            1: begin
               path_bytes.push_back(CharDot);
               path_bytes.push_back(CharDot);
            end
            2: begin
               repeat (3) path_bytes.push_back(CharDot);
            end
            3: begin
               path_bytes.push_back(CharDot);
               path_bytes.push_back(CharDot);
               path_bytes.push_back(random_letter());
            end
            default: begin
               n_char = $urandom_range(1, 5);
               repeat (n_char) begin
                  if ($urandom_range(0, 7) == 0) begin
                     path_bytes.push_back(8'($urandom_range(1, 255)));
                  end else begin
                     path_bytes.push_back(random_letter());
                  end
               end
            end
         endcase
         if (k < n_comp - 1 || $urandom_range(0, 3) == 0) begin
            path_bytes.push_back(random_sep());
            if ($urandom_range(0, 5) == 0) begin
               path_bytes.push_back(random_sep());
            end
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         path_bytes.push_back(CharColon);
      end
      path_bytes.push_back(CharNul);
   endfunction

   task automatic write_mask(logic [MountWidth-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      mount_mask = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      do begin
         @(negedge clock);
      end while (path_bytes.size() != 0 || req_if.valid || expected_beats.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [MountWidth-1:0] mask;
      int                    target;
      req_if.valid     = 1'b0;
      req_if.char_code = CharNul;
      rsp_if.ready     = 1'b0;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      mount_mask       = '0;
      clear_walk();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_mask({MountWidth{1'b1}});
      push_text("");
      push_text("x");
      push_text("z:/\\");
      push_text("..");
      push_text("a:b:");
      path_bytes.push_back("1");
      path_bytes.push_back(CharColon);
      path_bytes.push_back(8'hFF);
      path_bytes.push_back(CharNul);
      push_text("B:\200\\..\\q");
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: mask = '0;
            2: mask = 26'h1555555;
            4: mask = {MountWidth{1'b1}};
            default: mask = MountWidth'($urandom);
         endcase
         write_mask(mask);
         if (ph == 1) begin
            add_long_path(MaxBytes - 1);
         end
         if (ph == 3) begin
            add_long_path($urandom_range(MaxBytes, MaxBytes + 4));
         end
         target = path_bytes.size() + 80;
         while (path_bytes.size() < target) begin
            add_random_path();
         end
         if (path_bytes[$] != CharNul) begin
            path_bytes.push_back(CharNul);
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
